FILE: rtl/csl_pkg.sv
package csl_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int MODE_W      = 4;
  localparam int STATUS_W    = 2;

  localparam int IN_W   = MODE_W + VALUE_WIDTH + IDX_W;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = STATUS_W + VALUE_WIDTH + 1 + CNT_W + CNT_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_START        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_END          = 4'd1;
  localparam logic [MODE_W-1:0] MODE_ADVANCE      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_RETREAT      = 4'd3;
  localparam logic [MODE_W-1:0] MODE_INSERT       = 4'd4;
  localparam logic [MODE_W-1:0] MODE_ATTACH       = 4'd5;
  localparam logic [MODE_W-1:0] MODE_REMOVE_CUR   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_INSERT_FRONT = 4'd7;
  localparam logic [MODE_W-1:0] MODE_APPEND       = 4'd8;
  localparam logic [MODE_W-1:0] MODE_REMOVE_FRONT = 4'd9;
  localparam logic [MODE_W-1:0] MODE_READ_INDEX   = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ITEM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd3;

  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] pos;
    value_t           value;
  } shift_cmd_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [STATUS_W-1:0] status;
    logic                has_current;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    cursor;
  } read_req_t;

endpackage

FILE: rtl/cursor_sequence_list_unit.sv
// flow: an accepted request shifts the whole cell row and updates count and cursor,
//   then the read state selects one cell through an or-tree into the output register,
//   waiting while that register is still full; only then is a new request taken
// reset: rst is synchronous active high; count, cursor, state and m_tvalid clear,
//   entry cells keep unknown contents until written
module cursor_sequence_list_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // mode[3:0], entry_value[35:4], read_position[41:36], zero fill
  input  logic [csl_pkg::IN_TW-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status[1:0], read_value[33:2], has_current[34], entry_count[41:35],
  // cursor_position[48:42], zero fill
  output logic [csl_pkg::OUT_TW-1:0]   m_tdata
);
  import csl_pkg::*;

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_READ = 1'b1;

  logic state;
  logic fire;

  // unpacked request fields
  logic [MODE_W-1:0] mode;
  value_t            entry_value;
  logic [IDX_W-1:0]  read_position;

  shift_cmd_t cmd;
  read_req_t  req;

  // cell row wiring: each cell sees its neighbors' current entries
  value_t cell_value [DEPTH];
  value_t cell_rd    [DEPTH];
  value_t read_value;

  logic [OUT_W-1:0] out_data;

  assign mode          = s_tdata[MODE_W-1:0];
  assign entry_value   = s_tdata[MODE_W +: VALUE_WIDTH];
  assign read_position = s_tdata[MODE_W + VALUE_WIDTH +: IDX_W];

  // one request in flight; the next is taken once the read has been captured
  assign s_tready = (state == STATE_IDLE);
  assign fire     = s_tvalid && s_tready;

  csl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .mode          (mode),
    .entry_value   (entry_value),
    .read_position (read_position),
    .cmd           (cmd),
    .req           (req)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t left_in;
    value_t right_in;

    // open shifts toward higher positions, close toward lower ones
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_left
      assign left_in = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_right
      assign right_in = cell_value[i+1];
    end

    csl_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .idx     (IDX_W'(i)),
      .left    (left_in),
      .right   (right_in),
      .rd_en   (req.en),
      .rd_addr (req.addr),
      .value   (cell_value[i]),
      .rd_data (cell_rd[i])
    );
  end

  // only the addressed cell drives a nonzero word
  always_comb begin
    read_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_value = read_value | cell_rd[i];
    end
  end

  assign out_data = {req.cursor, req.count, req.has_current, read_value, req.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= STATE_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        STATE_IDLE: begin
          if (m_tready) m_tvalid <= 1'b0;
          if (fire) state <= STATE_READ;
        end
        STATE_READ: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= STATE_IDLE;
          end
        end
        default: state <= STATE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == STATE_READ && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_TW'(out_data);
    end
  end

endmodule

FILE: rtl/csl_cell.sv
module csl_cell (
  input  logic                      clk,
  input  csl_pkg::shift_cmd_t       cmd,
  input  logic [csl_pkg::IDX_W-1:0] idx,
  input  csl_pkg::value_t           left,
  input  csl_pkg::value_t           right,
  input  logic                      rd_en,
  input  logic [csl_pkg::IDX_W-1:0] rd_addr,
  output csl_pkg::value_t           value,
  output csl_pkg::value_t           rd_data
);
  import csl_pkg::*;

  value_t entry;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_OPEN: begin
        if (idx > cmd.pos) begin
          entry <= left;
        end else if (idx == cmd.pos) begin
          entry <= cmd.value;
        end
      end
      OP_CLOSE: begin
        if (idx >= cmd.pos) begin
          entry <= right;
        end
      end
      default: begin
      end
    endcase
  end

  assign value   = entry;
  assign rd_data = (rd_en && (rd_addr == idx)) ? entry : '0;

endmodule

FILE: rtl/csl_ctrl.sv
module csl_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [csl_pkg::MODE_W-1:0]   mode,
  input  csl_pkg::value_t              entry_value,
  input  logic [csl_pkg::IDX_W-1:0]    read_position,
  output csl_pkg::shift_cmd_t          cmd,
  output csl_pkg::read_req_t           req
);
  import csl_pkg::*;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    cursor;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    cursor_next;
  logic [STATUS_W-1:0] status;
  logic [1:0]          op;
  logic [CNT_W-1:0]    op_pos;
  logic                full;
  logic                has;
  logic                pos_ok;
  logic [CNT_W:0]      cursor_inc;
  read_req_t           req_next;

  assign full       = (count == CNT_W'(DEPTH));
  assign has        = (cursor < count);
  assign pos_ok     = ({1'b0, read_position} < count);
  assign cursor_inc = {1'b0, cursor} + (CNT_W + 1)'(1);

  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    status      = ST_OK;
    op          = OP_HOLD;
    op_pos      = '0;
    case (mode)
      MODE_START: cursor_next = '0;
      MODE_END: begin
        if (count == '0) status = ST_NO_ITEM;
        else cursor_next = count - CNT_W'(1);
      end
      MODE_ADVANCE: begin
        if (has) cursor_next = cursor + CNT_W'(1);
        else status = ST_NO_ITEM;
      end
      MODE_RETREAT: begin
        if (cursor != '0) cursor_next = cursor - CNT_W'(1);
      end
      MODE_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cursor_next = has ? cursor : '0;
          op          = OP_OPEN;
          op_pos      = cursor_next;
          count_next  = count + CNT_W'(1);
        end
      end
      MODE_ATTACH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          // step past the current entry, or go to the back
          cursor_next = (cursor_inc < {1'b0, count}) ? cursor_inc[CNT_W-1:0] : count;
          op          = OP_OPEN;
          op_pos      = cursor_next;
          count_next  = count + CNT_W'(1);
        end
      end
      MODE_REMOVE_CUR: begin
        if (has) begin
          op         = OP_CLOSE;
          op_pos     = cursor;
          count_next = count - CNT_W'(1);
        end else begin
          status = ST_NO_ITEM;
        end
      end
      MODE_INSERT_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cursor_next = '0;
          op          = OP_OPEN;
          count_next  = count + CNT_W'(1);
        end
      end
      MODE_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cursor_next = count;
          op          = OP_OPEN;
          op_pos      = count;
          count_next  = count + CNT_W'(1);
        end
      end
      MODE_REMOVE_FRONT: begin
        if (count != '0) begin
          op         = OP_CLOSE;
          count_next = count - CNT_W'(1);
        end else begin
          status = ST_NO_ITEM;
        end
      end
      MODE_READ_INDEX: begin
        if (!pos_ok) status = ST_OUT_RANGE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.op    = fire ? op : OP_HOLD;
    cmd.pos   = op_pos[IDX_W-1:0];
    cmd.value = entry_value;

    req_next.status      = status;
    req_next.has_current = (cursor_next < count_next);
    req_next.count       = count_next;
    req_next.cursor      = cursor_next;
    if (mode == MODE_READ_INDEX) begin
      req_next.en   = pos_ok;
      req_next.addr = read_position;
    end else begin
      req_next.en   = (cursor_next < count_next);
      req_next.addr = cursor_next[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
    end else if (fire) begin
      count  <= count_next;
      cursor <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      req <= req_next;
    end
  end

endmodule

FILE: tb/cursor_sequence_list_checker.sv
module cursor_sequence_list_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [csl_pkg::IN_TW-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [csl_pkg::OUT_TW-1:0] m_tdata,
  output int                         mismatches,
  output int                         outstanding,
  output int                         results_seen,
  output int                         full_seen
);
  import csl_pkg::*;

  // result field offsets
  localparam int RV_LO  = STATUS_W;
  localparam int HC_BIT = RV_LO + VALUE_WIDTH;
  localparam int CNT_LO = HC_BIT + 1;
  localparam int CUR_LO = CNT_LO + CNT_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    value_t              read_value;
    logic                has_current;
    logic [CNT_W-1:0]    entry_count;
    logic [CNT_W-1:0]    cursor_position;
  } list_reply_t;

  value_t      cells [DEPTH];
  int unsigned fill;
  int unsigned cur;
  list_reply_t predicted_replies [$];
  list_reply_t want;

  function automatic void open_slot(input int unsigned at, input value_t v);
    for (int unsigned i = fill; i > at; i--) cells[i] = cells[i-1];
    cells[at] = v;
    fill++;
  endfunction

  function automatic void close_slot(input int unsigned at);
    for (int unsigned i = at; i + 1 < fill; i++) cells[i] = cells[i+1];
    fill--;
  endfunction

  // applies one list operation and returns the reply it should give
  function automatic list_reply_t apply_list_op(input logic [MODE_W-1:0] op, input value_t v,
                                                input logic [IDX_W-1:0] at);
    list_reply_t r;
    logic        by_index;
    logic        full;
    r        = '0;
    by_index = 1'b0;
    full     = (fill >= DEPTH);
    r.status = ST_OK;
    case (op)
      MODE_START: cur = 0;
      MODE_END: begin
        if (fill == 0) r.status = ST_NO_ITEM;
        else cur = fill - 1;
      end
      MODE_ADVANCE: begin
        if (cur < fill) cur++;
        else r.status = ST_NO_ITEM;
      end
      MODE_RETREAT: begin
        if (cur > 0) cur--;
      end
      MODE_INSERT: begin
        if (full) r.status = ST_FULL;
        else begin
          if (cur >= fill) cur = 0;
          open_slot(cur, v);
        end
      end
      MODE_ATTACH: begin
        if (full) r.status = ST_FULL;
        else begin
          cur = (cur + 1 < fill) ? cur + 1 : fill;
          open_slot(cur, v);
        end
      end
      MODE_REMOVE_CUR: begin
        if (cur < fill) close_slot(cur);
        else r.status = ST_NO_ITEM;
      end
      MODE_INSERT_FRONT: begin
        if (full) r.status = ST_FULL;
        else begin
          cur = 0;
          open_slot(0, v);
        end
      end
      MODE_APPEND: begin
        if (full) r.status = ST_FULL;
        else begin
          cur = fill;
          open_slot(fill, v);
        end
      end
      MODE_REMOVE_FRONT: begin
        if (fill > 0) close_slot(0);
        else r.status = ST_NO_ITEM;
      end
      MODE_READ_INDEX: begin
        by_index = 1'b1;
        if (at < fill) r.read_value = cells[at];
        else r.status = ST_OUT_RANGE;
      end
      default: ;
    endcase
    if (!by_index && cur < fill) r.read_value = cells[cur];
    r.has_current     = (cur < fill);
    r.entry_count     = CNT_W'(fill);
    r.cursor_position = CNT_W'(cur);
    return r;
  endfunction

  task automatic check_field(input string name, input value_t exp_v, input value_t got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      cur  = 0;
      predicted_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tdata[STATUS_W-1:0] == ST_FULL) full_seen++;
        if (predicted_replies.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("status", value_t'(want.status), value_t'(m_tdata[STATUS_W-1:0]));
          check_field("read_value", want.read_value, m_tdata[RV_LO +: VALUE_WIDTH]);
          check_field("has_current", value_t'(want.has_current), value_t'(m_tdata[HC_BIT]));
          check_field("entry_count", value_t'(want.entry_count),
                      value_t'(m_tdata[CNT_LO +: CNT_W]));
          check_field("cursor_position", value_t'(want.cursor_position),
                      value_t'(m_tdata[CUR_LO +: CNT_W]));
        end
      end
      if (s_tvalid && s_tready)
        predicted_replies.push_back(apply_list_op(s_tdata[MODE_W-1:0],
                                                  s_tdata[MODE_W +: VALUE_WIDTH],
                                                  s_tdata[MODE_W + VALUE_WIDTH +: IDX_W]));
    end
    outstanding = predicted_replies.size();
  end

endmodule

FILE: tb/cursor_sequence_list_unit_tb.sv
module cursor_sequence_list_unit_tb;
  import csl_pkg::*;

  localparam int     PHASE_ITEMS = 290;   // minimum random requests per idle/stall phase
  localparam int     HOLD_CYCLES = 300;   // long output hold-off
  localparam int     QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int     DRAIN_WAIT  = 8;     // settle time after the last result
  localparam int     GROW        = 0;
  localparam int     SHRINK      = 1;
  localparam int     MIXED       = 2;
  localparam value_t MAX_POS     = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t MIN_NEG     = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam int     UNUSED_MODES = (1 << MODE_W) - 1 - MODE_READ_INDEX;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_TW-1:0]  s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;

  int idle_pct  = 0;   // chance the sender skips a cycle
  int stall_pct = 0;   // chance the receiver drops tready
  bit hold_go   = 1'b0;
  int sent      = 0;
  int quiet     = 0;
  int mismatches, outstanding, results_seen, full_seen;

  always #5 clk = ~clk;

  cursor_sequence_list_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // watches both channels, predicts every result and counts mismatches
  cursor_sequence_list_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .full_seen    (full_seen)
  );

  // no handshake for too long means the block hung
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("cursor_sequence_list_unit: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_go = 1'b0;
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offers one request, keeps tvalid up until it is taken
  task automatic send_req(input logic [MODE_W-1:0] op, input value_t v,
                          input logic [IDX_W-1:0] at);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TW-IN_W){1'b0}}, at, v, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // random request, mode mix leaning toward filling, draining or neither
  task automatic send_random(input int bias);
    int                pick;
    logic [MODE_W-1:0] op;
    value_t            v;
    logic [IDX_W-1:0]  at;
    pick = $urandom_range(0, 99);
    if (bias == GROW) begin
      if      (pick < 20) op = MODE_APPEND;
      else if (pick < 35) op = MODE_INSERT_FRONT;
      else if (pick < 55) op = MODE_INSERT;
      else if (pick < 70) op = MODE_ATTACH;
      else if (pick < 78) op = MODE_READ_INDEX;
      else if (pick < 84) op = MODE_ADVANCE;
      else if (pick < 88) op = MODE_RETREAT;
      else if (pick < 92) op = MODE_START;
      else if (pick < 96) op = MODE_END;
      else if (pick < 98) op = MODE_REMOVE_CUR;
      else op = MODE_W'(MODE_READ_INDEX + $urandom_range(1, UNUSED_MODES));
    end else if (bias == SHRINK) begin
      if      (pick < 25) op = MODE_REMOVE_FRONT;
      else if (pick < 50) op = MODE_REMOVE_CUR;
      else if (pick < 60) op = MODE_ADVANCE;
      else if (pick < 65) op = MODE_RETREAT;
      else if (pick < 70) op = MODE_START;
      else if (pick < 75) op = MODE_END;
      else if (pick < 85) op = MODE_READ_INDEX;
      else if (pick < 90) op = MODE_APPEND;
      else if (pick < 95) op = MODE_INSERT;
      else op = MODE_W'(MODE_READ_INDEX + $urandom_range(1, UNUSED_MODES));
    end else begin
      if (pick < 5) op = MODE_W'(MODE_READ_INDEX + $urandom_range(1, UNUSED_MODES));
      else          op = MODE_W'($urandom_range(MODE_START, MODE_READ_INDEX));
    end
    // mostly full random words, some corner values
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = MAX_POS;
        1:       v = MIN_NEG;
        2:       v = '0;
        default: v = '1;
      endcase
    end else begin
      v = $urandom;
    end
    // half the reads aim at the low positions that usually hold entries
    if ($urandom_range(0, 1)) at = IDX_W'($urandom_range(0, DEPTH - 1));
    else                      at = IDX_W'($urandom_range(0, 15));
    send_req(op, v, at);
  endtask

  initial begin
    int n;
    int seg_len;
    int bias;
    bit pressed;
    pressed = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-list cases first
    send_req(MODE_REMOVE_FRONT, '0, '0);       // remove front, empty
    send_req(MODE_END, '0, '0);                // cursor to end, empty
    send_req(MODE_ADVANCE, '0, '0);            // advance, no current item
    send_req(MODE_REMOVE_CUR, '0, '0);         // remove at cursor, no current item
    send_req(MODE_READ_INDEX, '0, '0);         // read past count
    send_req(MODE_RETREAT, '0, '0);            // retreat at position zero
    send_req(MODE_INSERT, MAX_POS, '0);        // insert without current item
    send_req(MODE_ATTACH, MIN_NEG, '0);        // attach when cursor is last
    send_req(MODE_START, '0, '0);
    send_req(MODE_ATTACH, '0, '0);             // attach in the middle
    send_req(MODE_ADVANCE, '0, '0);
    send_req(MODE_ADVANCE, '0, '0);            // steps off the end
    send_req(MODE_ATTACH, '1, '0);             // attach without current item
    send_req(MODE_ADVANCE, '0, '0);
    send_req(MODE_INSERT, 32'h5555_5555, '0);  // insert without current item again
    send_req(MODE_INSERT_FRONT, 32'haaaa_aaaa, '0);
    send_req(MODE_APPEND, 32'h1234_5678, '0);
    send_req(MODE_END, '0, '0);
    send_req(MODE_RETREAT, '0, '0);
    send_req(MODE_READ_INDEX, '0, '1);         // highest position, out of range
    send_req(MODE_READ_INDEX, '0, 6'd2);
    send_req(MODE_REMOVE_CUR, '0, '0);
    send_req(MODE_REMOVE_FRONT, '0, '0);
    for (int u = 1; u <= UNUSED_MODES; u++)    // unused mode codes do nothing
      send_req(MODE_W'(MODE_READ_INDEX + u), '1, '1);

    // random: four idle/stall phases, each opening with a run biased toward filling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 55; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (n == 0) begin
          seg_len = 100;
          bias    = GROW;
        end else begin
          seg_len = $urandom_range(40, 120);
          bias    = $urandom_range(GROW, MIXED);
        end
        repeat (seg_len) send_random(bias);
        n += seg_len;
        // long output hold-off while requests keep coming, block must back up
        if (ph == 0 && !pressed && n >= 100) begin
          hold_go = 1'b1;
          pressed = 1'b1;
        end
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    stall_pct = 0;
    wait (outstanding == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d requests: directed corners, fill/drain runs, four idle/stall phases",
             sent);
    $display("checked %0d results, %0d on a full list, one %0d-cycle output hold-off",
             results_seen, full_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("cursor_sequence_list_unit: match");
    end else begin
      $display("cursor_sequence_list_unit: mismatch");
    end
    $finish;
  end

endmodule
